// ----- rtl/epxf_pkg.sv -----
`timescale 1ns / 1ps
package epxf_pkg;

   // Field widths of the stream words.
   localparam int SAMPLE_BITS   = 24;
   localparam int POS_BITS      = 24;
   localparam int CHAN_BITS     = 4;
   localparam int CIDX_BITS     = 3;
   localparam int REQ_DATA_BITS = 72;
   localparam int CSR_DATA_BITS = 24;
   localparam int CSR_IDX_BITS  = 1;

   localparam int MAX_CHANNELS = 8;
   localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

   // Gain table: quarter-wave sine in Q1.16, TABLE_SIZE+1 entries.
   localparam int TABLE_SIZE = 1024;
   localparam int IDX_BITS   = $clog2(TABLE_SIZE + 1);
   localparam int GAIN_BITS  = 17;
   localparam int GAIN_FRAC  = 16;
   localparam longint GAIN_ONE    = 65536;
   localparam longint HALF_PI_Q30 = 64'sd1686629713;

   // Serial divider and multiply-accumulate sizes.
   localparam int REM_BITS    = POS_BITS + 1;
   localparam int DIV_STEPS   = IDX_BITS;
   localparam int MUL_STEPS   = GAIN_BITS;
   localparam int CNT_BITS    = $clog2(MUL_STEPS);
   localparam int ACC_BITS    = SAMPLE_BITS + GAIN_BITS + 3;
   localparam int MAC_HI_BITS = ACC_BITS - GAIN_BITS;
   localparam int RND_BITS    = ACC_BITS - GAIN_FRAC;
   localparam longint ROUND_HALF = 32768;

   // Configuration register indexes.
   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_FADE_FRAMES   = 1'b0,
      CSR_CHANNEL_COUNT = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_READ_COS,
      ST_READ_SIN,
      ST_LOAD_GAIN,
      ST_MULTIPLY,
      ST_FINISH
   } state_type;

   typedef enum logic [1:0] {
      MODE_OUT,
      MODE_IN,
      MODE_MIX
   } mode_type;

   // Control of the serial units.
   typedef struct packed {
      logic load;
      logic step;
   } unit_ctrl_type;

   typedef logic [GAIN_BITS-1:0] gain_table_type [TABLE_SIZE+1];

   // Taylor divisors (2n)(2n+1) for n = 1..7.
   localparam longint TAYLOR_DIV [7] = '{6, 20, 42, 72, 110, 156, 210};

   // Builds the sine table with a Q2.30 Taylor series, rounded to Q1.16.
   function automatic gain_table_type build_gain_table();
      gain_table_type tbl;
      longint x;
      longint x2;
      longint term;
      longint sum;
      longint g;
      for (int k = 0; k <= TABLE_SIZE; k++) begin
         x    = (HALF_PI_Q30 * longint'(k) + longint'(TABLE_SIZE / 2)) / TABLE_SIZE;
         x2   = (x * x) >>> 30;
         term = x;
         sum  = x;
         for (int n = 1; n <= 7; n++) begin
            term = ((term * x2) >>> 30) / TAYLOR_DIV[n-1];
            if (n % 2 == 1) begin
               sum = sum - term;
            end else begin
               sum = sum + term;
            end
         end
         if (sum < 0) begin
            sum = 0;
         end
         g = (sum + 64'sd8192) >>> 14;
         if (g > GAIN_ONE) begin
            g = GAIN_ONE;
         end
         tbl[k] = g[GAIN_BITS-1:0];
      end
      return tbl;
   endfunction

   localparam gain_table_type GAIN_TABLE = build_gain_table();

endpackage

// ----- rtl/epxf_div.sv -----
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per step: (pos * 2 * TABLE_SIZE + fade) / (2 * fade).
module epxf_div (
   input  logic                             clock,
   input  epxf_pkg::unit_ctrl_type          ctrl,
   input  logic [epxf_pkg::POS_BITS-1:0]    position,
   input  logic [epxf_pkg::POS_BITS-1:0]    fade,
   output logic [epxf_pkg::IDX_BITS-1:0]    quotient
);

   logic [epxf_pkg::REM_BITS-1:0] rem_ff, rem_in;
   logic [epxf_pkg::REM_BITS-1:0] divisor_ff, divisor_in;
   logic [epxf_pkg::IDX_BITS-1:0] low_ff, low_in;
   logic [epxf_pkg::IDX_BITS-1:0] quot_ff, quot_in;
   logic [epxf_pkg::REM_BITS:0]   trial;
   logic                          fits;

   // The numerator's low bits are the fade length's low bits; the high part starts the remainder.
   always_comb begin
      trial = {rem_ff, low_ff[epxf_pkg::IDX_BITS-1]};
      fits  = trial >= {1'b0, divisor_ff};
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      low_in     = low_ff;
      quot_in    = quot_ff;
      if (ctrl.load) begin
         rem_in     = epxf_pkg::REM_BITS'(position)
                    + epxf_pkg::REM_BITS'(fade >> epxf_pkg::IDX_BITS);
         divisor_in = {fade, 1'b0};
         low_in     = fade[epxf_pkg::IDX_BITS-1:0];
         quot_in    = '0;
      end else if (ctrl.step) begin
         rem_in  = fits ? epxf_pkg::REM_BITS'(trial - {1'b0, divisor_ff})
                        : trial[epxf_pkg::REM_BITS-1:0];
         low_in  = {low_ff[epxf_pkg::IDX_BITS-2:0], 1'b0};
         quot_in = {quot_ff[epxf_pkg::IDX_BITS-2:0], fits};
      end
   end

   always_ff @(posedge clock) begin
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
      low_ff     <= low_in;
      quot_ff    <= quot_in;
   end

   assign quotient = quot_ff;

endmodule

// ----- rtl/epxf_mac.sv -----
`timescale 1ns / 1ps
// Bit-serial dual multiply-accumulate: out * gain_out + in * gain_in, gain bits LSB first.
module epxf_mac (
   input  logic                                   clock,
   input  epxf_pkg::unit_ctrl_type                ctrl,
   input  logic signed [epxf_pkg::SAMPLE_BITS-1:0] sample_out,
   input  logic signed [epxf_pkg::SAMPLE_BITS-1:0] sample_in,
   input  logic [epxf_pkg::GAIN_BITS-1:0]         gain_out,
   input  logic [epxf_pkg::GAIN_BITS-1:0]         gain_in,
   output logic signed [epxf_pkg::ACC_BITS-1:0]   acc
);

   logic signed [epxf_pkg::MAC_HI_BITS-1:0] hi_ff, hi_in;
   logic [epxf_pkg::GAIN_BITS-1:0]          lo_ff, lo_in;
   logic [epxf_pkg::GAIN_BITS-1:0]          g_out_ff, g_out_in;
   logic [epxf_pkg::GAIN_BITS-1:0]          g_in_ff, g_in_in;
   logic signed [epxf_pkg::SAMPLE_BITS:0]   part;
   logic signed [epxf_pkg::MAC_HI_BITS-1:0] total;

   // Add the partial product of this gain bit to the upper half, then shift one bit down.
   always_comb begin
      part = (g_out_ff[0] ? (epxf_pkg::SAMPLE_BITS+1)'(sample_out) : '0)
           + (g_in_ff[0]  ? (epxf_pkg::SAMPLE_BITS+1)'(sample_in)  : '0);
      total = hi_ff + epxf_pkg::MAC_HI_BITS'(part);
      hi_in    = hi_ff;
      lo_in    = lo_ff;
      g_out_in = g_out_ff;
      g_in_in  = g_in_ff;
      if (ctrl.load) begin
         hi_in    = '0;
         lo_in    = '0;
         g_out_in = gain_out;
         g_in_in  = gain_in;
      end else if (ctrl.step) begin
         hi_in    = total >>> 1;
         lo_in    = {total[0], lo_ff[epxf_pkg::GAIN_BITS-1:1]};
         g_out_in = g_out_ff >> 1;
         g_in_in  = g_in_ff >> 1;
      end
   end

   always_ff @(posedge clock) begin
      hi_ff    <= hi_in;
      lo_ff    <= lo_in;
      g_out_ff <= g_out_in;
      g_in_ff  <= g_in_in;
   end

   assign acc = {hi_ff, lo_ff};

endmodule

// ----- rtl/equal_power_crossfade_mixer.sv -----
`timescale 1ns / 1ps
// Words are taken one at a time: the input opens only in the idle state. While mixing, a word
// goes through its load, 11 divider steps, the cosine read, the sine read, the gain load,
// 17 multiply steps and finish; a sample that passes unchanged goes from its load to finish.
// A result waiting in the output register does not block acceptance of the next word.
// Synchronous active-high reset clears the control state, the frame position, the channel
// index and the registers (fade length 0, two channels).
module equal_power_crossfade_mixer (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [epxf_pkg::REQ_DATA_BITS-1:0]    req_tdata,  // out_sample, in_sample, start_frame
   input  logic                                  req_tuser,  // block_start
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [epxf_pkg::SAMPLE_BITS-1:0]      rsp_tdata,  // mixed_sample
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [epxf_pkg::CSR_IDX_BITS-1:0]     csr_index,
   input  logic [epxf_pkg::CSR_DATA_BITS-1:0]    csr_data
);

   localparam int SB = epxf_pkg::SAMPLE_BITS;
   localparam int PB = epxf_pkg::POS_BITS;
   localparam int IB = epxf_pkg::IDX_BITS;

   epxf_pkg::state_type state_ff, state_in;
   epxf_pkg::mode_type  mode_ff, mode_in;

   logic [PB-1:0]                         fade_frames_ff;
   logic [epxf_pkg::CHAN_BITS-1:0]        channel_count_ff;
   logic [PB-1:0]                         frame_position_ff, frame_position_in;
   logic [epxf_pkg::CIDX_BITS-1:0]        channel_index_ff, channel_index_in;
   logic signed [SB-1:0]                  a_ff, b_ff;
   logic [epxf_pkg::CNT_BITS-1:0]         count_ff;
   logic [epxf_pkg::GAIN_BITS-1:0]        rom_q_ff, gain_out_ff;
   logic                                  rsp_tvalid_ff;
   logic [SB-1:0]                         rsp_tdata_ff, rsp_tdata_in;

   logic                                  req_fire;
   logic                                  out_free;
   logic                                  rsp_load;
   logic [IB-1:0]                         rom_addr;
   logic [IB-1:0]                         quotient, idx;
   epxf_pkg::unit_ctrl_type               div_ctrl, mac_ctrl;
   logic signed [epxf_pkg::ACC_BITS-1:0]  acc;

   logic [PB-1:0]                         pos_cur;
   logic [epxf_pkg::CIDX_BITS-1:0]        cidx_cur;
   logic [epxf_pkg::CHAN_BITS-1:0]        chans_clamp, chans_step, cidx_next;
   logic                                  wrap;

   logic signed [epxf_pkg::ACC_BITS-1:0]  rounded_acc;
   logic signed [epxf_pkg::RND_BITS-1:0]  rounded;
   logic                                  in_range;
   logic signed [SB-1:0]                  mixed;

   // Frame position and channel index for the word at the input.
   always_comb begin
      pos_cur     = req_tuser ? req_tdata[3*SB-1:2*SB] : frame_position_ff;
      cidx_cur    = req_tuser ? '0 : channel_index_ff;
      chans_clamp = (channel_count_ff > epxf_pkg::CHAN_BITS'(epxf_pkg::MAX_CHANNELS))
                  ? epxf_pkg::CHAN_BITS'(epxf_pkg::MAX_CHANNELS) : channel_count_ff;
      chans_step  = (chans_clamp == '0) ? epxf_pkg::CHAN_BITS'(1) : chans_clamp;
      cidx_next   = {1'b0, cidx_cur} + epxf_pkg::CHAN_BITS'(1);
      wrap        = cidx_next >= chans_step;
      channel_index_in  = wrap ? '0 : cidx_next[epxf_pkg::CIDX_BITS-1:0];
      frame_position_in = (wrap && (pos_cur != epxf_pkg::POS_MAX))
                        ? pos_cur + PB'(1) : pos_cur;
      if ((fade_frames_ff == '0) || (chans_clamp == '0)) begin
         mode_in = epxf_pkg::MODE_OUT;
      end else if (pos_cur >= fade_frames_ff) begin
         mode_in = epxf_pkg::MODE_IN;
      end else begin
         mode_in = epxf_pkg::MODE_MIX;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         epxf_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               state_in = (mode_in == epxf_pkg::MODE_MIX) ? epxf_pkg::ST_DIVIDE
                                                          : epxf_pkg::ST_FINISH;
            end
         end
         epxf_pkg::ST_DIVIDE: begin
            if (count_ff == '0) begin
               state_in = epxf_pkg::ST_READ_COS;
            end
         end
         epxf_pkg::ST_READ_COS:  state_in = epxf_pkg::ST_READ_SIN;
         epxf_pkg::ST_READ_SIN:  state_in = epxf_pkg::ST_LOAD_GAIN;
         epxf_pkg::ST_LOAD_GAIN: state_in = epxf_pkg::ST_MULTIPLY;
         epxf_pkg::ST_MULTIPLY: begin
            if (count_ff == '0) begin
               state_in = epxf_pkg::ST_FINISH;
            end
         end
         epxf_pkg::ST_FINISH: begin
            if (out_free) begin
               state_in = epxf_pkg::ST_IDLE;
            end
         end
         default: state_in = epxf_pkg::ST_IDLE;
      endcase
   end

   // State machine outputs.
   always_comb begin
      out_free      = !rsp_tvalid_ff || rsp_tready;
      req_tready    = (state_ff == epxf_pkg::ST_IDLE);
      req_fire      = req_tready && req_tvalid;
      div_ctrl.load = req_fire;
      div_ctrl.step = (state_ff == epxf_pkg::ST_DIVIDE);
      mac_ctrl.load = (state_ff == epxf_pkg::ST_LOAD_GAIN);
      mac_ctrl.step = (state_ff == epxf_pkg::ST_MULTIPLY);
      rsp_load      = (state_ff == epxf_pkg::ST_FINISH) && out_free;
      idx           = (quotient > IB'(epxf_pkg::TABLE_SIZE)) ? IB'(epxf_pkg::TABLE_SIZE)
                                                             : quotient;
      rom_addr      = (state_ff == epxf_pkg::ST_READ_COS)
                    ? IB'(epxf_pkg::TABLE_SIZE) - idx : idx;
   end

   epxf_div u_div (
      .clock    (clock),
      .ctrl     (div_ctrl),
      .position (pos_cur),
      .fade     (fade_frames_ff),
      .quotient (quotient)
   );

   epxf_mac u_mac (
      .clock      (clock),
      .ctrl       (mac_ctrl),
      .sample_out (a_ff),
      .sample_in  (b_ff),
      .gain_out   (gain_out_ff),
      .gain_in    (rom_q_ff),
      .acc        (acc)
   );

   // Round half up, then saturate to the sample width.
   always_comb begin
      rounded_acc = acc + epxf_pkg::ACC_BITS'(epxf_pkg::ROUND_HALF);
      rounded     = rounded_acc[epxf_pkg::ACC_BITS-1:epxf_pkg::GAIN_FRAC];
      in_range    = (&rounded[epxf_pkg::RND_BITS-1:SB-1])
                 || !(|rounded[epxf_pkg::RND_BITS-1:SB-1]);
      if (in_range) begin
         mixed = rounded[SB-1:0];
      end else if (rounded[epxf_pkg::RND_BITS-1]) begin
         mixed = {1'b1, {(SB-1){1'b0}}};
      end else begin
         mixed = {1'b0, {(SB-1){1'b1}}};
      end
      unique case (mode_ff)
         epxf_pkg::MODE_OUT: rsp_tdata_in = a_ff;
         epxf_pkg::MODE_IN:  rsp_tdata_in = b_ff;
         default:            rsp_tdata_in = mixed;
      endcase
   end

   // Control state, counters and configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= epxf_pkg::ST_IDLE;
         fade_frames_ff    <= '0;
         channel_count_ff  <= epxf_pkg::CHAN_BITS'(2);
         frame_position_ff <= '0;
         channel_index_ff  <= '0;
         count_ff          <= '0;
         rsp_tvalid_ff     <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) begin
            if (csr_index == epxf_pkg::CSR_FADE_FRAMES) begin
               fade_frames_ff <= csr_data[PB-1:0];
            end else if (csr_index == epxf_pkg::CSR_CHANNEL_COUNT) begin
               channel_count_ff <= csr_data[epxf_pkg::CHAN_BITS-1:0];
            end
         end
         if (req_fire) begin
            frame_position_ff <= frame_position_in;
            channel_index_ff  <= channel_index_in;
         end
         if (req_fire) begin
            count_ff <= epxf_pkg::CNT_BITS'(epxf_pkg::DIV_STEPS - 1);
         end else if (state_ff == epxf_pkg::ST_LOAD_GAIN) begin
            count_ff <= epxf_pkg::CNT_BITS'(epxf_pkg::MUL_STEPS - 1);
         end else if (div_ctrl.step || mac_ctrl.step) begin
            count_ff <= count_ff - epxf_pkg::CNT_BITS'(1);
         end
         if (rsp_load) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
      end
   end

   // Payload registers and the gain table read port.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         a_ff    <= req_tdata[SB-1:0];
         b_ff    <= req_tdata[2*SB-1:SB];
         mode_ff <= mode_in;
      end
      rom_q_ff <= epxf_pkg::GAIN_TABLE[rom_addr];
      if (state_ff == epxf_pkg::ST_READ_SIN) begin
         gain_out_ff <= rom_q_ff;
      end
      if (rsp_load) begin
         rsp_tdata_ff <= rsp_tdata_in;
      end
   end

   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

endmodule

// ----- rtl/epxf_checker.sv -----
`timescale 1ns / 1ps
module epxf_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [epxf_pkg::SAMPLE_BITS-1:0] rsp_tdata
);

   // Reset empties the output register.
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result word valid after reset");

   // One word at a time: the input closes right after an accepted word.
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("input still open after an accepted word");

   // A result never shows up on the edge right after an accept.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> !$past(req_tvalid && req_tready))
      else $error("result word appeared too early");

   // A stalled result word holds.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled result word changed");

endmodule

bind equal_power_crossfade_mixer epxf_checker u_checker (.*);
